// ----- src/ssd_pkg.sv -----
// Shared constants, codes and types for the seven-segment scan controller.
// No dependencies; ssd_cfg and the top level refer to it by scoped names.
`default_nettype none

package ssd_pkg;

  localparam int DIGITS      = 4;
  localparam int DIG_W       = $clog2(DIGITS);
  localparam int SEG_BITS    = 8;
  localparam logic [7:0] SEG_MASK = 8'((9'd1 << SEG_BITS) - 9'd1);
  localparam int SLIDE_DEPTH = 64;

  localparam int FULL_BRIGHT = 100;
  // floor(x / 100) == (x * 5243) >> 19 for every x below 43690
  localparam int RECIP_100   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int SCALE_W     = 20;

  localparam int CFG_AW      = 4;
  localparam int CFG_DW      = 32;

  localparam logic [6:0]  BRIGHT_RST = 7'd100;
  localparam logic [7:0]  PERIOD_RST = 8'd4;
  localparam logic [15:0] STEP_RST   = 16'd500;
  localparam logic [15:0] HALF_RST   = 16'd1000;

  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_WR_DIGIT = 2'd1,
    OP_WR_SLIDE = 2'd2,
    OP_START    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    DM_SHOW   = 3'd0,
    DM_TIMED  = 3'd1,
    DM_LOOP   = 3'd2,
    DM_ONCE   = 3'd3,
    DM_SELECT = 3'd4,
    DM_BLINK  = 3'd5
  } disp_mode_e;

  typedef enum logic [1:0] {
    REG_BRIGHT = 2'd0,
    REG_PERIOD = 2'd1,
    REG_STEP   = 2'd2,
    REG_HALF   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [SCALE_W-1:0] bright_scale;
    logic [7:0]         period;
    logic [7:0]         period_m1;
    logic [15:0]        step_m1;
    logic [15:0]        half_m1;
  } cfg_t;

endpackage

`default_nettype wire

// ----- src/ssd_in_if.sv -----
// Input channel of the scan controller: valid/ready plus one item.
// Depends on nothing.
`default_nettype none

interface ssd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [5:0]  position;
  logic [7:0]  pattern;
  logic [2:0]  display_mode;
  logic [1:0]  select_index;
  logic [23:0] duration_ticks;
  logic [6:0]  slide_length;

  modport source (
    output valid, mode, position, pattern, display_mode, select_index,
           duration_ticks, slide_length,
    input  ready
  );
  modport sink (
    input  valid, mode, position, pattern, display_mode, select_index,
           duration_ticks, slide_length,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/ssd_out_if.sv -----
// Result channel of the scan controller: valid/ready plus one result.
// Depends on nothing.
`default_nettype none

interface ssd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] segments;
  logic [1:0] digit_select;
  logic [2:0] active_mode;

  modport source (output valid, segments, digit_select, active_mode, input ready);
  modport sink   (input valid, segments, digit_select, active_mode, output ready);
endinterface

`default_nettype wire

// ----- src/ssd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module ssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/ssd_cfg.sv -----
// APB-style register file: brightness, digit period, slide step, blink half.
// Depends on ssd_pkg; hands derived reload values to the core as ssd_pkg::cfg_t.
`default_nettype none

module ssd_cfg (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel_i,
  input  wire logic                       penable_i,
  input  wire logic                       pwrite_i,
  input  wire logic [ssd_pkg::CFG_AW-1:0] paddr_i,
  input  wire logic [ssd_pkg::CFG_DW-1:0] pwdata_i,
  output      logic [ssd_pkg::CFG_DW-1:0] prdata_o,
  output      logic                       pready_o,
  output      ssd_pkg::cfg_t              cfg_o
);

  logic [6:0]                      bright_q;
  logic [ssd_pkg::SCALE_W-1:0]     scale_q;
  logic [7:0]                      period_q;
  logic [15:0]                     step_q;
  logic [15:0]                     half_q;
  logic                            wr_en;
  ssd_pkg::cfg_reg_e               reg_sel;
  logic [6:0]                      bright_clamp;
  logic [ssd_pkg::SCALE_W-1:0]     scale_new;

  assign reg_sel = ssd_pkg::cfg_reg_e'(paddr_i[3:2]);
  assign wr_en   = psel_i && penable_i && pwrite_i;

  assign bright_clamp = (pwdata_i[6:0] > 7'(ssd_pkg::FULL_BRIGHT)) ?
                        7'(ssd_pkg::FULL_BRIGHT) : pwdata_i[6:0];
  assign scale_new = ssd_pkg::SCALE_W'(bright_clamp) *
                     ssd_pkg::SCALE_W'(ssd_pkg::RECIP_100);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= ssd_pkg::BRIGHT_RST;
      scale_q  <= ssd_pkg::SCALE_W'(ssd_pkg::FULL_BRIGHT * ssd_pkg::RECIP_100);
      period_q <= ssd_pkg::PERIOD_RST;
      step_q   <= ssd_pkg::STEP_RST;
      half_q   <= ssd_pkg::HALF_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        ssd_pkg::REG_BRIGHT: begin
          bright_q <= pwdata_i[6:0];
          scale_q  <= scale_new;
        end
        ssd_pkg::REG_PERIOD: period_q <= pwdata_i[7:0];
        ssd_pkg::REG_STEP:   step_q   <= pwdata_i[15:0];
        ssd_pkg::REG_HALF:   half_q   <= pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ssd_pkg::REG_BRIGHT: prdata_o = ssd_pkg::CFG_DW'(bright_q);
      ssd_pkg::REG_PERIOD: prdata_o = ssd_pkg::CFG_DW'(period_q);
      ssd_pkg::REG_STEP:   prdata_o = ssd_pkg::CFG_DW'(step_q);
      ssd_pkg::REG_HALF:   prdata_o = ssd_pkg::CFG_DW'(half_q);
      default:             prdata_o = '0;
    endcase
  end

  assign pready_o = 1'b1;

  // zero period, step or half period counts as one
  assign cfg_o.bright_scale = scale_q;
  assign cfg_o.period       = (period_q == 8'd0) ? 8'd1 : period_q;
  assign cfg_o.period_m1    = (period_q == 8'd0) ? 8'd0 : period_q - 8'd1;
  assign cfg_o.step_m1      = (step_q == 16'd0) ? 16'd0 : step_q - 16'd1;
  assign cfg_o.half_m1      = (half_q == 16'd0) ? 16'd0 : half_q - 16'd1;

endmodule

`default_nettype wire

// ----- src/seven_segment_scan_controller.sv -----
// Four-digit multiplexed seven-segment scan controller, top level.
// Each accepted input beat gives its result beat in the next cycle.
// Throughput: one beat per cycle while each result is taken; the result register frees as it is taken.
// Reset: digits, counters and mode return to their defaults at once; the
// slide store RAM is not cleared and holds garbage until written.
// Depends on ssd_pkg, ssd_in_if, ssd_out_if, ssd_ram and ssd_cfg.
`default_nettype none

module seven_segment_scan_controller #(
  parameter int SLIDE_DEPTH = ssd_pkg::SLIDE_DEPTH
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  ssd_in_if.sink                          in_i,
  ssd_out_if.source                       out_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ssd_pkg::CFG_AW-1:0] paddr,
  input  wire logic [ssd_pkg::CFG_DW-1:0] pwdata,
  output      logic [ssd_pkg::CFG_DW-1:0] prdata,
  output      logic                       pready
);

  localparam int DW = ssd_pkg::DIG_W;
  localparam int ND = ssd_pkg::DIGITS;
  localparam int AW = $clog2(SLIDE_DEPTH);
  localparam int CW = $clog2(SLIDE_DEPTH + 1);
  localparam int PW = $clog2(SLIDE_DEPTH + ND + 1);
  localparam int SHIFT = ssd_pkg::RECIP_SHIFT;
  localparam int PROD_W = ssd_pkg::SCALE_W + 8;

  ssd_pkg::cfg_t cfg;

  ssd_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  logic                    accept;
  logic                    out_valid_q, out_valid_d;
  ssd_pkg::op_e            op;
  ssd_pkg::disp_mode_e     dm_in;

  ssd_pkg::disp_mode_e     mode_q, mode_d;
  logic [7:0]              digits_q [ND];
  logic [7:0]              digits_d [ND];
  logic [DW-1:0]           scan_q, scan_d;
  logic [DW-1:0]           enabled_q, enabled_d;
  logic [7:0]              period_q, period_d;
  logic [7:0]              duty_q, duty_d;
  logic                    blanked_q, blanked_d;
  logic [15:0]             slide_cnt_q, slide_cnt_d;
  logic [PW-1:0]           pos_q, pos_d;
  logic [CW-1:0]           count_q, count_d;
  logic [23:0]             timed_q, timed_d;
  logic [15:0]             blink_cnt_q, blink_cnt_d;
  logic                    dark_q, dark_d;
  logic [DW-1:0]           blink_dig_q, blink_dig_d;
  logic [7:0]              saved_q, saved_d;
  logic [7:0]              latch_q, latch_d;

  logic [7:0]              duty_mid;
  logic                    blanked_mid;
  logic [PROD_W-1:0]       duty_prod;
  logic [7:0]              duty_base;
  logic [7:0]              duty_load;
  logic [DW-1:0]           sel_idx;
  logic [CW-1:0]           len_clamp;
  logic [PW-1:0]           pos_inc;
  logic [PW:0]             pos_end;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [AW-1:0]           ram_raddr;
  logic [7:0]              ram_rdata;
  logic                    fwd_hit_q;
  logic [7:0]              fwd_q;
  logic [7:0]              slide_data;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign accept      = in_i.valid && in_i.ready;
  assign out_valid_d = accept || (out_valid_q && !out_o.ready);
  assign op          = ssd_pkg::op_e'(in_i.mode);
  assign dm_in       = ssd_pkg::disp_mode_e'(in_i.display_mode);

  assign duty_prod = PROD_W'(cfg.bright_scale) * PROD_W'(cfg.period);
  assign duty_base = duty_prod[SHIFT +: 8];
  assign duty_load = (duty_base == 8'd0) ? 8'd0 : duty_base - 8'd1;

  assign sel_idx   = (32'(in_i.select_index) < ND) ? DW'(in_i.select_index) : DW'(ND - 1);
  assign len_clamp = (32'(in_i.slide_length) < SLIDE_DEPTH) ?
                     CW'(in_i.slide_length) : CW'(SLIDE_DEPTH);
  assign pos_inc   = pos_q + PW'(1);
  assign pos_end   = (PW + 1)'(count_q) + (PW + 1)'(ND);

  // slide store: reread the next position every cycle, bypass a same-cycle write
  assign ram_we     = accept && (op == ssd_pkg::OP_WR_SLIDE) &&
                      (32'(in_i.position) < SLIDE_DEPTH);
  assign ram_waddr  = AW'(in_i.position);
  assign ram_raddr  = pos_d[AW-1:0];
  assign slide_data = fwd_hit_q ? fwd_q : ram_rdata;

  ssd_ram #(
    .WIDTH (8),
    .DEPTH (SLIDE_DEPTH)
  ) u_slide_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.pattern),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    mode_d      = mode_q;
    digits_d    = digits_q;
    scan_d      = scan_q;
    enabled_d   = enabled_q;
    period_d    = period_q;
    duty_d      = duty_q;
    blanked_d   = blanked_q;
    slide_cnt_d = slide_cnt_q;
    pos_d       = pos_q;
    count_d     = count_q;
    timed_d     = timed_q;
    blink_cnt_d = blink_cnt_q;
    dark_d      = dark_q;
    blink_dig_d = blink_dig_q;
    saved_d     = saved_q;
    latch_d     = latch_q;
    duty_mid    = duty_q;
    blanked_mid = blanked_q;

    if (accept) begin
      unique case (op)
        ssd_pkg::OP_TICK: begin
          case (mode_q) inside
            ssd_pkg::DM_TIMED: begin
              if (timed_q == 24'd0) begin
                for (int i = 0; i < ND; i++) begin
                  digits_d[i] = 8'd0;
                end
                mode_d = ssd_pkg::DM_SHOW;
              end else begin
                timed_d = timed_q - 24'd1;
              end
            end
            ssd_pkg::DM_LOOP, ssd_pkg::DM_ONCE: begin
              if (slide_cnt_q == 16'd0) begin
                slide_cnt_d = cfg.step_m1;
                for (int i = 0; i < ND - 1; i++) begin
                  digits_d[i] = digits_q[i + 1];
                end
                digits_d[ND - 1] = ((PW + 1)'(pos_q) < (PW + 1)'(count_q)) ?
                                   slide_data : 8'd0;
                pos_d = pos_inc;
                if ((PW + 1)'(pos_inc) >= pos_end) begin
                  if (mode_q == ssd_pkg::DM_ONCE) begin
                    mode_d = ssd_pkg::DM_SHOW;
                  end else begin
                    pos_d = '0;
                  end
                end
              end else begin
                slide_cnt_d = slide_cnt_q - 16'd1;
              end
            end
            ssd_pkg::DM_BLINK: begin
              if (blink_cnt_q == 16'd0) begin
                digits_d[blink_dig_q] = dark_q ? 8'd0 : saved_q;
                dark_d      = !dark_q;
                blink_cnt_d = cfg.half_m1;
              end else begin
                blink_cnt_d = blink_cnt_q - 16'd1;
              end
            end
            default: ;
          endcase

          if (period_q == 8'd0) begin
            enabled_d   = scan_q;
            latch_d     = digits_d[scan_q];
            scan_d      = (scan_q == DW'(ND - 1)) ? '0 : scan_q + DW'(1);
            period_d    = cfg.period_m1;
            duty_mid    = duty_load;
            blanked_mid = 1'b0;
          end else begin
            period_d = period_q - 8'd1;
          end

          blanked_d = blanked_mid;
          if (duty_mid == 8'd0) begin
            duty_d = 8'd0;
            if (!blanked_mid) begin
              latch_d   = 8'd0;
              blanked_d = 1'b1;
            end
          end else begin
            duty_d = duty_mid - 8'd1;
          end
        end

        ssd_pkg::OP_WR_DIGIT: begin
          if (32'(in_i.position) < ND) begin
            digits_d[in_i.position[DW-1:0]] = in_i.pattern;
          end
        end

        ssd_pkg::OP_WR_SLIDE: ;

        ssd_pkg::OP_START: begin
          unique case (dm_in)
            ssd_pkg::DM_SHOW: mode_d = ssd_pkg::DM_SHOW;
            ssd_pkg::DM_TIMED: begin
              mode_d  = ssd_pkg::DM_TIMED;
              timed_d = (in_i.duration_ticks == 24'd0) ? 24'd0 :
                        in_i.duration_ticks - 24'd1;
            end
            ssd_pkg::DM_LOOP, ssd_pkg::DM_ONCE: begin
              mode_d      = dm_in;
              count_d     = len_clamp;
              slide_cnt_d = cfg.step_m1;
              pos_d       = '0;
            end
            ssd_pkg::DM_SELECT: begin
              mode_d            = ssd_pkg::DM_SELECT;
              digits_d[sel_idx] = digits_q[sel_idx] | 8'd1;
            end
            ssd_pkg::DM_BLINK: begin
              mode_d      = ssd_pkg::DM_BLINK;
              blink_dig_d = sel_idx;
              saved_d     = digits_q[sel_idx];
              blink_cnt_d = cfg.half_m1;
              dark_d      = 1'b0;
            end
            default: ;
          endcase
        end

        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mode_q      <= ssd_pkg::DM_SHOW;
      for (int i = 0; i < ND; i++) begin
        digits_q[i] <= 8'd0;
      end
      scan_q      <= '0;
      enabled_q   <= '0;
      period_q    <= ssd_pkg::PERIOD_RST - 8'd1;
      duty_q      <= ssd_pkg::PERIOD_RST - 8'd1;
      blanked_q   <= 1'b0;
      slide_cnt_q <= ssd_pkg::STEP_RST - 16'd1;
      pos_q       <= '0;
      count_q     <= '0;
      timed_q     <= '0;
      blink_cnt_q <= ssd_pkg::HALF_RST - 16'd1;
      dark_q      <= 1'b0;
      blink_dig_q <= '0;
      saved_q     <= 8'd0;
      latch_q     <= 8'd0;
      fwd_hit_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      mode_q      <= mode_d;
      digits_q    <= digits_d;
      scan_q      <= scan_d;
      enabled_q   <= enabled_d;
      period_q    <= period_d;
      duty_q      <= duty_d;
      blanked_q   <= blanked_d;
      slide_cnt_q <= slide_cnt_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
      timed_q     <= timed_d;
      blink_cnt_q <= blink_cnt_d;
      dark_q      <= dark_d;
      blink_dig_q <= blink_dig_d;
      saved_q     <= saved_d;
      latch_q     <= latch_d;
      fwd_hit_q   <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_q <= in_i.pattern;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.segments     = latch_q & ssd_pkg::SEG_MASK;
  assign out_o.digit_select = 2'(enabled_q);
  assign out_o.active_mode  = 3'(mode_q);

endmodule

`default_nettype wire
